FILE: sv/erm_pkg.sv
// Types, register indexes and helper functions for the e/gamma region merge block.
`default_nettype none

package erm_pkg;

  localparam int unsigned EtW = 10;
  localparam int unsigned IsoW = 7;
  localparam int unsigned RecW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned ProdW = EtW + IsoW;
  localparam int unsigned IsoFrac = 6;

  localparam logic [CfgIdxW-1:0] CfgSeedThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIsoFactor = 1'b1;

  localparam logic [EtW-1:0] SeedThresholdReset = 10'd0;
  localparam logic [IsoW-1:0] IsoFactorReset = 7'd64;

  // Peak phi locations that meet across a region boundary.
  localparam logic [1:0] PhiLocLow = 2'd0;
  localparam logic [1:0] PhiLocHigh = 2'd2;

  typedef struct packed {
    logic [EtW-1:0]  center_et;
    logic            center_veto;
    logic [1:0]      center_phi_loc;
    logic [1:0]      center_eta_loc;
    logic            edge_column;
    logic [EtW-1:0]  sum_3by3;
    logic [RecW-1:0] north_neighbor;
    logic [RecW-1:0] south_neighbor;
    logic [RecW-1:0] west_neighbor;
    logic [RecW-1:0] east_neighbor;
  } erm_in_t;

  typedef struct packed {
    logic [EtW-1:0] candidate_et;
    logic [EtW-1:0] isolated_et;
  } erm_out_t;

  // One neighbor after decode: act = merge is attempted, win = neighbor is added.
  typedef struct packed {
    logic           act;
    logic           win;
    logic [EtW-1:0] et;
  } erm_dir_t;

  typedef struct packed {
    logic [EtW-1:0] run;
    logic [EtW-1:0] s33;
    erm_dir_t       north;
    erm_dir_t       south;
    erm_dir_t       west;
    erm_dir_t       east;
  } erm_dec_t;

  typedef struct packed {
    logic [EtW-1:0] run;
    logic [EtW-1:0] s33;
    erm_dir_t       west;
    erm_dir_t       east;
  } erm_mid_t;

  typedef struct packed {
    logic [EtW-1:0] cand;
    logic [EtW-1:0] s33;
  } erm_cand_t;

  function automatic logic eta_close(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] d;
    d = {1'b0, a} - {1'b0, b};
    return (d == 3'd0) || (d == 3'd1) || (d == 3'b111);
  endfunction

  function automatic erm_dir_t decode_nbr(
    input logic [RecW-1:0] rec,
    input logic [EtW-1:0]  c_et,
    input logic [1:0]      c_phi,
    input logic [1:0]      c_eta,
    input logic            center_up,
    input logic            strict
  );
    erm_dir_t   r;
    logic       touch;
    logic [1:0] phi;
    logic [1:0] eta;
    phi = rec[3:2];
    eta = rec[5:4];
    r.et = rec[15:6];
    touch = center_up ? (c_phi == PhiLocHigh && phi == PhiLocLow)
                      : (c_phi == PhiLocLow && phi == PhiLocHigh);
    r.act = rec[0] & ~rec[1] & touch & eta_close(c_eta, eta);
    r.win = strict ? (c_et > r.et) : (c_et >= r.et);
    return r;
  endfunction

  function automatic logic [EtW-1:0] merge_step(input logic [EtW-1:0] run,
                                                input erm_dir_t d);
    logic [EtW-1:0] r;
    r = run;
    if (d.act) begin
      r = d.win ? (run + d.et) : '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/erm_decode.sv
// First stage: seed test and decode of the four neighbor records.
`default_nettype none

module erm_decode import erm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire erm_in_t        item_i,
  input  wire logic [EtW-1:0] seed_thr_i,
  output logic                valid_o,
  output erm_dec_t            dec_o
);

  logic     valid_q;
  erm_dec_t dec_d, dec_q;
  logic     seed;

  always_comb begin
    seed = ~item_i.edge_column & ~item_i.center_veto & (item_i.center_et > seed_thr_i);
    dec_d.run = seed ? item_i.center_et : '0;
    dec_d.s33 = item_i.edge_column ? '0 : item_i.sum_3by3;
    dec_d.north = decode_nbr(item_i.north_neighbor, item_i.center_et,
                             item_i.center_phi_loc, item_i.center_eta_loc, 1'b1, 1'b0);
    dec_d.south = decode_nbr(item_i.south_neighbor, item_i.center_et,
                             item_i.center_phi_loc, item_i.center_eta_loc, 1'b0, 1'b1);
    dec_d.west = decode_nbr(item_i.west_neighbor, item_i.center_et,
                            item_i.center_phi_loc, item_i.center_eta_loc, 1'b0, 1'b0);
    dec_d.east = decode_nbr(item_i.east_neighbor, item_i.center_et,
                            item_i.center_phi_loc, item_i.center_eta_loc, 1'b1, 1'b1);
    // Drop all merges when there is no seed.
    dec_d.north.act = dec_d.north.act & seed;
    dec_d.south.act = dec_d.south.act & seed;
    dec_d.west.act = dec_d.west.act & seed;
    dec_d.east.act = dec_d.east.act & seed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
  end

  assign valid_o = valid_q;
  assign dec_o = dec_q;

endmodule

`default_nettype wire

FILE: sv/erm_merge.sv
// Merge stages: north and south in one stage, west and east in the next.
`default_nettype none

module erm_merge import erm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire erm_dec_t dec_i,
  output logic          valid_o,
  output erm_cand_t     cand_o
);

  logic      mid_valid_q, cand_valid_q;
  erm_mid_t  mid_d, mid_q;
  erm_cand_t cand_d, cand_q;

  always_comb begin
    mid_d.run = merge_step(merge_step(dec_i.run, dec_i.north), dec_i.south);
    mid_d.s33 = dec_i.s33;
    mid_d.west = dec_i.west;
    mid_d.east = dec_i.east;
  end

  always_comb begin
    cand_d.cand = merge_step(merge_step(mid_q.run, mid_q.west), mid_q.east);
    cand_d.s33 = mid_q.s33;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      cand_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= valid_i;
      cand_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    cand_q <= cand_d;
  end

  assign valid_o = cand_valid_q;
  assign cand_o = cand_q;

endmodule

`default_nettype wire

FILE: sv/erm_iso.sv
// Isolation stages: scale the candidate, then compare against the surrounding energy.
`default_nettype none

module erm_iso import erm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire erm_cand_t       cand_i,
  input  wire logic [IsoW-1:0] iso_factor_i,
  output logic                 valid_o,
  output erm_out_t             res_o
);

  logic             mul_valid_q, res_valid_q;
  logic [EtW-1:0]   cand_q;
  logic [EtW-1:0]   isol_d, isol_q;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [EtW-1:0]   limit;
  erm_out_t         res_d, res_q;

  always_comb begin
    isol_d = (cand_i.s33 > cand_i.cand) ? (cand_i.s33 - cand_i.cand) : '0;
    prod_d = {{EtW{1'b0}}, iso_factor_i} * {{IsoW{1'b0}}, cand_i.cand};
  end

  always_comb begin
    // Truncate the fraction bits, wrap to the energy width.
    limit = prod_q[IsoFrac +: EtW];
    res_d.candidate_et = cand_q;
    res_d.isolated_et = (isol_q < limit) ? cand_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      res_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_i.cand;
    isol_q <= isol_d;
    prod_q <= prod_d;
    res_q <= res_d;
  end

  assign valid_o = res_valid_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: sv/egamma_region_merge_isolation.sv
// Top level of the e/gamma region merge and isolation pipeline.
// One item is taken in every clock cycle: busy stays low, so any cycle with
// start high accepts an item. Each item yields one result on res_o, marked by
// result_valid_o for one cycle; results leave in the order items came in and the
// receiver cannot hold them back. The five register stages are: seed test and
// neighbor decode, north/south merge, west/east merge, the isolation multiply,
// and the isolation compare. Configuration writes through cfg_we_i take effect
// at once and should be made while no item is in flight.
`default_nettype none

module egamma_region_merge_isolation import erm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire erm_in_t             in_item_i,
  output logic                     result_valid_o,
  output erm_out_t                 res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [EtW-1:0]  seed_thr_q;
  logic [IsoW-1:0] iso_factor_q;
  logic            dec_valid, cand_valid;
  erm_dec_t        dec;
  erm_cand_t       cand;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_thr_q <= SeedThresholdReset;
      iso_factor_q <= IsoFactorReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSeedThreshold: seed_thr_q <= cfg_wdata_i[EtW-1:0];
        CfgIsoFactor:     iso_factor_q <= cfg_wdata_i[IsoW-1:0];
        default: ;
      endcase
    end
  end

  erm_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start & ~busy),
    .item_i     (in_item_i),
    .seed_thr_i (seed_thr_q),
    .valid_o    (dec_valid),
    .dec_o      (dec)
  );

  erm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .dec_i   (dec),
    .valid_o (cand_valid),
    .cand_o  (cand)
  );

  erm_iso u_iso (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (cand_valid),
    .cand_i       (cand),
    .iso_factor_i (iso_factor_q),
    .valid_o      (result_valid_o),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

FILE: sv/erm_checker.sv
// Port-level checks for the e/gamma region merge block, bound to the top level.
`default_nettype none

module erm_checker import erm_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     result_valid_o,
  input wire erm_out_t res_o
);

  // Every accepted item comes out as a result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 result_valid_o)
    else $error("accepted item did not produce a result");

  // No result without a matching accepted item.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 5))
    else $error("result without a matching item");

  // Isolated energy is either zero or the candidate itself.
  a_iso_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (res_o.isolated_et == '0 ||
                        res_o.isolated_et == res_o.candidate_et))
    else $error("isolated energy differs from candidate");

  // A zero candidate never passes isolation.
  a_zero_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.candidate_et == '0) |-> res_o.isolated_et == '0)
    else $error("zero candidate marked isolated");

endmodule

bind egamma_region_merge_isolation erm_checker u_erm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the e/gamma region merge and isolation block.
`default_nettype none

module tb;
  import erm_pkg::*;

  localparam int PipeDepth = 5;
  localparam int ItemsPerPhase = 75;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    erm_in_t  region;
    logic     typed;
    erm_out_t want;
  } region_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  erm_in_t             in_item_i = '0;
  logic                result_valid_o;
  erm_out_t            res_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgSeedThreshold;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Register copies used by the predictor
  logic [EtW-1:0]  model_seed = SeedThresholdReset;
  logic [IsoW-1:0] model_iso = IsoFactorReset;

  erm_out_t    pending_results[$];
  region_row_t directed_rows[$];
  erm_out_t    arrived_want;
  int          errors_found = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          seeded_seen = 0;
  int          isolated_seen = 0;
  int          cycle_count = 0;

  logic [EtW-1:0]  phase_seed[6] = '{10'd0, 10'd1023, 10'd50, 10'd200, 10'd0, 10'd400};
  logic [IsoW-1:0] phase_iso[6] = '{7'd0, 7'd127, 7'd127, 7'd32, 7'd96, 7'd64};

  egamma_region_merge_isolation dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_item_i      (in_item_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic logic [RecW-1:0] make_neighbor(input bit present, input bit veto,
                                                    input logic [1:0] phi,
                                                    input logic [1:0] eta,
                                                    input logic [EtW-1:0] et);
    return {et, eta, phi, veto, present};
  endfunction

  function automatic erm_in_t make_region(input logic [EtW-1:0] et, input bit veto,
                                          input logic [1:0] phi, input logic [1:0] eta,
                                          input bit edge_col, input logic [EtW-1:0] s33,
                                          input logic [RecW-1:0] n, input logic [RecW-1:0] s,
                                          input logic [RecW-1:0] w, input logic [RecW-1:0] e);
    erm_in_t r;
    r.center_et = et;
    r.center_veto = veto;
    r.center_phi_loc = phi;
    r.center_eta_loc = eta;
    r.edge_column = edge_col;
    r.sum_3by3 = s33;
    r.north_neighbor = n;
    r.south_neighbor = s;
    r.west_neighbor = w;
    r.east_neighbor = e;
    return r;
  endfunction

  // One merge attempt: clear on a lost comparison, add (wrapping) on a win.
  function automatic logic [EtW-1:0] fold_neighbor(input logic [EtW-1:0] acc,
                                                   input logic [RecW-1:0] rec,
                                                   input erm_in_t c, input bit from_high,
                                                   input bit strict);
    logic [EtW-1:0] n_et;
    logic [1:0]     n_phi;
    int             eta_gap;
    bit             touches;
    bit             beats;
    n_et = rec[15:6];
    n_phi = rec[3:2];
    eta_gap = int'(c.center_eta_loc) - int'(rec[5:4]);
    if (eta_gap < 0) eta_gap = -eta_gap;
    touches = from_high ? (c.center_phi_loc == PhiLocHigh && n_phi == PhiLocLow)
                        : (c.center_phi_loc == PhiLocLow && n_phi == PhiLocHigh);
    if (!rec[0] || rec[1] || !touches || eta_gap >= 2) return acc;
    beats = strict ? (c.center_et > n_et) : (c.center_et >= n_et);
    return beats ? acc + n_et : '0;
  endfunction

  function automatic erm_out_t predict_region(input erm_in_t r);
    erm_out_t       res;
    logic [EtW-1:0] cand;
    logic [EtW-1:0] isol;
    logic [ProdW-1:0] scaled;
    res = '0;
    if (!r.edge_column) begin
      cand = '0;
      if (!r.center_veto && r.center_et > model_seed) begin
        cand = r.center_et;
        cand = fold_neighbor(cand, r.north_neighbor, r, 1'b1, 1'b0);
        cand = fold_neighbor(cand, r.south_neighbor, r, 1'b0, 1'b1);
        cand = fold_neighbor(cand, r.west_neighbor, r, 1'b0, 1'b0);
        cand = fold_neighbor(cand, r.east_neighbor, r, 1'b1, 1'b1);
      end
      isol = (r.sum_3by3 > cand) ? r.sum_3by3 - cand : '0;
      scaled = model_iso * cand;
      res.candidate_et = cand;
      if (isol < scaled[15:6]) res.isolated_et = cand;
    end
    return res;
  endfunction

  // Mostly touching, non-vetoed neighbors with energy near the center's.
  function automatic logic [RecW-1:0] random_neighbor(input logic [EtW-1:0] c_et,
                                                      input logic [1:0] c_eta,
                                                      input logic [1:0] touch_phi);
    logic [1:0]     phi;
    logic [1:0]     eta;
    logic [EtW-1:0] et;
    int             k;
    phi = ($urandom_range(3) != 0) ? touch_phi : 2'($urandom_range(3));
    k = int'(c_eta) + int'($urandom_range(2)) - 1;
    if (k < 0) k = 0;
    if (k > 3) k = 3;
    eta = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'(k);
    case ($urandom_range(3))
      0: et = c_et;
      1: et = c_et + 10'd1;
      2: et = c_et - 10'd1;
      default: et = 10'($urandom_range(1023));
    endcase
    return make_neighbor($urandom_range(7) != 0, $urandom_range(7) == 0, phi, eta, et);
  endfunction

  function automatic erm_in_t shape_region();
    erm_in_t        r;
    logic [95:0]    noise;
    logic [EtW-1:0] low_et;
    noise = {$urandom(), $urandom(), $urandom()};
    r = noise[$bits(erm_in_t)-1:0];
    if ($urandom_range(99) < 25) return r;
    low_et = (model_seed == 10'd1023) ? 10'd0 : model_seed + 10'd1;
    r.center_et = 10'($urandom_range(1023, low_et));
    r.center_veto = ($urandom_range(9) == 0);
    r.edge_column = ($urandom_range(15) == 0);
    if ($urandom_range(4) == 0) r.center_phi_loc = 2'($urandom_range(3));
    else r.center_phi_loc = $urandom_range(1) ? PhiLocHigh : PhiLocLow;
    r.center_eta_loc = 2'($urandom_range(3));
    r.sum_3by3 = $urandom_range(1) ? 10'($urandom_range(1023))
                                   : r.center_et + 10'($urandom_range(255));
    r.north_neighbor = random_neighbor(r.center_et, r.center_eta_loc, PhiLocLow);
    r.south_neighbor = random_neighbor(r.center_et, r.center_eta_loc, PhiLocHigh);
    r.west_neighbor = random_neighbor(r.center_et, r.center_eta_loc, PhiLocHigh);
    r.east_neighbor = random_neighbor(r.center_et, r.center_eta_loc, PhiLocLow);
    return r;
  endfunction

  function automatic void add_row(input erm_in_t region, input bit typed,
                                  input logic [EtW-1:0] cand, input logic [EtW-1:0] iso);
    region_row_t row;
    row.region = region;
    row.typed = typed;
    row.want = {cand, iso};
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    errors_found++;
  endtask

  task automatic send_region(input erm_in_t region, input bit typed, input erm_out_t want);
    start <= 1'b1;
    in_item_i <= region;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(typed ? want : predict_region(region));
    items_sent++;
  endtask

  task automatic write_settings(input logic [EtW-1:0] seed, input logic [IsoW-1:0] iso);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgSeedThreshold;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_idx_i <= CfgIsoFactor;
    cfg_wdata_i <= CfgDataW'(iso);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_seed = seed;
    model_iso = iso;
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (res_o.candidate_et != 0) seeded_seen++;
      if (res_o.isolated_et != 0) isolated_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, candidate_et", res_o.candidate_et, 0);
      end else begin
        arrived_want = pending_results.pop_front();
        if (res_o.candidate_et !== arrived_want.candidate_et)
          report_mismatch("candidate_et", res_o.candidate_et, arrived_want.candidate_et);
        if (res_o.isolated_et !== arrived_want.isolated_et)
          report_mismatch("isolated_et", res_o.isolated_et, arrived_want.isolated_et);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             pending_results.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    int idle_pct;
    int random_idx;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: seed above 0, isolation factor 1.0
    add_row(make_region(10'd0, 0, 2'd0, 2'd0, 0, 10'd0, '0, '0, '0, '0), 1, 10'd0, 10'd0);
    add_row(make_region(10'd1023, 0, PhiLocHigh, 2'd1, 1, 10'd0,
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd5), '0, '0, '0),
            1, 10'd0, 10'd0);
    add_row(make_region(10'd500, 1, 2'd0, 2'd0, 0, 10'd0, '0, '0, '0, '0), 1, 10'd0, 10'd0);
    add_row(make_region(10'd1023, 0, 2'd1, 2'd0, 0, 10'd0, '0, '0, '0, '0),
            1, 10'd1023, 10'd1023);
    add_row(make_region(10'd1, 0, 2'd1, 2'd0, 0, 10'd1023, '0, '0, '0, '0), 1, 10'd1, 10'd0);
    // Isolation boundary: limit equals the candidate at factor 1.0
    add_row(make_region(10'd128, 0, 2'd1, 2'd0, 0, 10'd255, '0, '0, '0, '0),
            1, 10'd128, 10'd128);
    add_row(make_region(10'd128, 0, 2'd1, 2'd0, 0, 10'd256, '0, '0, '0, '0),
            1, 10'd128, 10'd0);
    // Merge comparisons at equal and near-equal energies, per direction
    add_row(make_region(10'd300, 0, PhiLocHigh, 2'd1, 0, 10'd600,
                        make_neighbor(1, 0, PhiLocLow, 2'd2, 10'd300), '0, '0, '0), 0, 0, 0);
    add_row(make_region(10'd300, 0, PhiLocHigh, 2'd1, 0, 10'd600,
                        make_neighbor(1, 0, PhiLocLow, 2'd0, 10'd301), '0, '0, '0), 0, 0, 0);
    add_row(make_region(10'd300, 0, PhiLocLow, 2'd1, 0, 10'd600,
                        '0, make_neighbor(1, 0, PhiLocHigh, 2'd1, 10'd300), '0, '0), 0, 0, 0);
    add_row(make_region(10'd300, 0, PhiLocLow, 2'd1, 0, 10'd700,
                        '0, make_neighbor(1, 0, PhiLocHigh, 2'd2, 10'd299), '0, '0), 0, 0, 0);
    add_row(make_region(10'd300, 0, PhiLocLow, 2'd2, 0, 10'd650,
                        '0, '0, make_neighbor(1, 0, PhiLocHigh, 2'd3, 10'd300), '0), 0, 0, 0);
    add_row(make_region(10'd300, 0, PhiLocHigh, 2'd2, 0, 10'd650,
                        '0, '0, '0, make_neighbor(1, 0, PhiLocLow, 2'd2, 10'd300)), 0, 0, 0);
    add_row(make_region(10'd300, 0, PhiLocHigh, 2'd3, 0, 10'd900,
                        make_neighbor(1, 0, PhiLocLow, 2'd3, 10'd200),
                        make_neighbor(1, 0, PhiLocHigh, 2'd3, 10'd100),
                        make_neighbor(1, 0, PhiLocHigh, 2'd3, 10'd50),
                        make_neighbor(1, 0, PhiLocLow, 2'd2, 10'd299)), 0, 0, 0);
    // Wraparound of the merge sum
    add_row(make_region(10'd1000, 0, PhiLocHigh, 2'd0, 0, 10'd1023,
                        make_neighbor(1, 0, PhiLocLow, 2'd0, 10'd900), '0, '0,
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd999)), 0, 0, 0);
    // Eta too far apart, vetoed neighbor, absent neighbor with all other bits set
    add_row(make_region(10'd400, 0, PhiLocHigh, 2'd0, 0, 10'd500,
                        make_neighbor(1, 0, PhiLocLow, 2'd2, 10'd10), '0, '0,
                        make_neighbor(1, 0, PhiLocLow, 2'd3, 10'd20)), 0, 0, 0);
    add_row(make_region(10'd400, 0, PhiLocHigh, 2'd3, 0, 10'd500,
                        make_neighbor(1, 0, PhiLocLow, 2'd0, 10'd10),
                        '0, '0, make_neighbor(1, 1, PhiLocLow, 2'd3, 10'd20)), 0, 0, 0);
    add_row(make_region(10'd400, 0, PhiLocHigh, 2'd1, 0, 10'd500,
                        16'hFFFE, '0, '0, 16'hFFF2), 0, 0, 0);
    // Clear by the north neighbor, then restart from zero with the east one
    add_row(make_region(10'd300, 0, PhiLocHigh, 2'd1, 0, 10'd200,
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd500), '0, '0,
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd100)), 0, 0, 0);
    // Peak locations that never touch
    add_row(make_region(10'd300, 0, 2'd1, 2'd1, 0, 10'd300,
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd5),
                        make_neighbor(1, 0, PhiLocHigh, 2'd1, 10'd5),
                        make_neighbor(1, 0, PhiLocHigh, 2'd1, 10'd5),
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd5)), 0, 0, 0);
    add_row(make_region(10'd300, 0, 2'd3, 2'd1, 0, 10'd300,
                        make_neighbor(1, 0, PhiLocLow, 2'd1, 10'd5), '0, '0,
                        make_neighbor(1, 0, 2'd3, 2'd1, 10'd5)), 0, 0, 0);
    add_row(make_region(10'd1023, 0, 2'd3, 2'd3, 0, 10'd1023,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0, 0);
    add_row('1, 1, 10'd0, 10'd0);

    foreach (directed_rows[i]) begin
      send_region(directed_rows[i].region, directed_rows[i].typed, directed_rows[i].want);
    end

    random_idx = 0;
    foreach (phase_seed[p]) begin
      drain_results();
      write_settings(phase_seed[p], phase_iso[p]);
      repeat (ItemsPerPhase) begin
        idle_pct = (random_idx < 150) ? 33 : (random_idx < 300) ? 78 : 0;
        // Idle each cycle with the phase's probability.
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
        send_region(shape_region(), 1'b0, '0);
        random_idx++;
      end
    end
    drain_results();

    $display("Sent %0d regions (%0d directed) over reset and %0d register settings",
             items_sent, directed_rows.size(), $size(phase_seed));
    $display("Checked %0d results: %0d seeded candidates, %0d isolated, %0d mismatches",
             results_seen, seeded_seen, isolated_seen, errors_found);
    if (errors_found == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/erm_pkg.sv
sv/erm_decode.sv
sv/erm_merge.sv
sv/erm_iso.sv
sv/egamma_region_merge_isolation.sv
sv/erm_checker.sv
verif/tb.sv
